/* src/skn_pkg.sv */
// Shared types, constants and helpers for the Skein-512-512 hash core.
// No dependencies.
package skn_pkg;

  typedef logic [63:0]       word_t;
  typedef logic [7:0][63:0]  blk_t;
  typedef logic [8:0][63:0]  key_t;
  typedef logic [2:0][63:0]  twk_t;

  localparam word_t KEY_PARITY = 64'h1BD11BDAA9FC1A22;

  localparam blk_t SKEIN_IV = {
    64'hAE18A40B660FCC33, 64'h991112C71A75B523,
    64'hEABE394CA9D5C3F4, 64'h5DB62599DF6CA7B0,
    64'h9A255629FF352CB1, 64'h8FD1934127C79BCE,
    64'h0D95DE399746DF03, 64'h4903ADFF749C51CE
  };

  // Tweak words for message block (tail and head) and output UBI
  localparam word_t TW0_TAIL = 64'd64;
  localparam word_t TW1_TAIL = 64'hF000000000000000;
  localparam word_t TW0_HEAD = 64'd80;
  localparam word_t TW1_HEAD = 64'hB000000000000000;
  localparam word_t TW0_OUT  = 64'd8;
  localparam word_t TW1_OUT  = 64'hFF00000000000000;

  localparam logic [4:0] LAST_SUBKEY = 5'd18;

  function automatic word_t bswap64(input word_t v);
    word_t r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
    return r;
  endfunction

  // Rotation constant for round d mod 8, mix i
  function automatic logic [5:0] rot_amt(input logic [2:0] d, input logic [1:0] i);
    logic [23:0] row;
    case (d)
      3'd0:    row = {6'd37, 6'd19, 6'd36, 6'd46};
      3'd1:    row = {6'd42, 6'd14, 6'd27, 6'd33};
      3'd2:    row = {6'd39, 6'd36, 6'd49, 6'd17};
      3'd3:    row = {6'd56, 6'd54, 6'd9,  6'd44};
      3'd4:    row = {6'd24, 6'd34, 6'd30, 6'd39};
      3'd5:    row = {6'd17, 6'd10, 6'd50, 6'd13};
      3'd6:    row = {6'd43, 6'd39, 6'd29, 6'd25};
      default: row = {6'd22, 6'd56, 6'd35, 6'd8};
    endcase
    return row[6*i +: 6];
  endfunction

endpackage

/* src/skn_round.sv */
// One Threefish-512 round: four MIX functions and the word permutation.
// Depends on skn_pkg.
module skn_round (
  input  skn_pkg::blk_t     x,
  input  logic [2:0]        d,
  output skn_pkg::blk_t     y
);
  import skn_pkg::*;

  blk_t m;

  // MIX on each pair
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [5:0] n;
      word_t      a;
      word_t      b;
      n = rot_amt(d, 2'(i));
      a = x[2*i] + x[2*i+1];
      b = (x[2*i+1] << n) | (x[2*i+1] >> (7'd64 - {1'b0, n}));
      m[2*i]   = a;
      m[2*i+1] = a ^ b;
    end
  end

  // Permutation
  assign y[0] = m[2];
  assign y[1] = m[1];
  assign y[2] = m[4];
  assign y[3] = m[7];
  assign y[4] = m[6];
  assign y[5] = m[5];
  assign y[6] = m[0];
  assign y[7] = m[3];

endmodule

/* src/skein512_hash_core_top.sv */
// Skein-512-512 hash core top level: word collection, Threefish sequencer, output.
// Depends on skn_pkg and skn_round.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tuser: operation; tdata: tag, data_word
// m_*      out  m_tvalid/m_tready    tdata: out_tag, hash_word; tlast: last_word
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (chain key words 0..7)
//
// One word per cycle is taken while collecting. After the last word of a message:
// a load state, then two Threefish passes (72 rounds each through the single
// round unit plus 19 subkey injections), then eight result words.
// Input is held off from the last word until the eighth result word is taken.
// Synchronous active-high reset; output words hold under m_tready low.
module skein512_hash_core_top #(
  parameter int TAG_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,   // operation
  input  logic [((TAG_BITS+64+7)/8)*8-1:0] s_tdata,  // tag, data_word
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((TAG_BITS+64+7)/8)*8-1:0] m_tdata,  // out_tag, hash_word
  output logic                    m_tlast,   // last_word
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_index,
  input  logic [63:0]             cfg_data
);
  import skn_pkg::*;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;
  localparam logic [2:0] S_INJ     = 3'd2;
  localparam logic [2:0] S_RND     = 3'd3;
  localparam logic [2:0] S_OUT     = 3'd4;

  logic [2:0]          state;
  logic [3:0]          word_count;
  logic                mode_held;
  logic [TAG_BITS-1:0] tag_held;
  blk_t                word_store;
  blk_t                chain_key;
  blk_t                blk;
  blk_t                x;
  blk_t                x_rnd;
  blk_t                x_inj;
  blk_t                hash;
  key_t                k;
  twk_t                t;
  logic [4:0]          subkey;
  logic [2:0]          rnd;
  logic                pass;
  logic [2:0]          out_cnt;
  logic [3:0]          need;
  logic                cur_mode;

  assign s_tready  = (state == S_COLLECT);
  assign cfg_ready = 1'b1;

  // Chain key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_key <= '0;
    end else if (cfg_valid && cfg_index[3] == 1'b0) begin
      chain_key[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Message block: byte-swapped words, zero padding in head mode
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk[i] = (mode_held || i < 2) ? bswap64(word_store[i]) : '0;
    end
  end

  // Subkey injection
  always_comb begin
    for (int i = 0; i < 8; i++) x_inj[i] = x[i] + k[i];
    x_inj[5] = x[5] + k[5] + t[0];
    x_inj[6] = x[6] + k[6] + t[1];
    x_inj[7] = x[7] + k[7] + {59'd0, subkey};
  end

  skn_round u_round (
    .x (x),
    .d (rnd),
    .y (x_rnd)
  );

  assign cur_mode = (word_count == 4'd0) ? s_tuser : mode_held;
  assign need     = cur_mode ? 4'd8 : 4'd2;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      word_count <= '0;
      mode_held  <= 1'b0;
      tag_held   <= '0;
      subkey     <= '0;
      rnd        <= '0;
      pass       <= 1'b0;
      out_cnt    <= '0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (s_tvalid) begin
            if (word_count == 4'd0) begin
              mode_held <= s_tuser;
              tag_held  <= s_tdata[TAG_BITS-1:0];
            end
            word_store[word_count[2:0]] <= s_tdata[TAG_BITS +: 64];
            if (word_count + 4'd1 == need) begin
              word_count <= '0;
              state      <= S_LOAD;
            end else begin
              word_count <= word_count + 4'd1;
            end
          end
        end
        S_LOAD: begin
          // First pass key and tweak
          for (int i = 0; i < 8; i++) k[i] <= mode_held ? SKEIN_IV[i] : chain_key[i];
          k[8] <= KEY_PARITY ^ (mode_held ? SKEIN_IV[0] : chain_key[0])
                  ^ (mode_held ? SKEIN_IV[1] : chain_key[1])
                  ^ (mode_held ? SKEIN_IV[2] : chain_key[2])
                  ^ (mode_held ? SKEIN_IV[3] : chain_key[3])
                  ^ (mode_held ? SKEIN_IV[4] : chain_key[4])
                  ^ (mode_held ? SKEIN_IV[5] : chain_key[5])
                  ^ (mode_held ? SKEIN_IV[6] : chain_key[6])
                  ^ (mode_held ? SKEIN_IV[7] : chain_key[7]);
          t[0] <= mode_held ? TW0_TAIL : TW0_HEAD;
          t[1] <= mode_held ? TW1_TAIL : TW1_HEAD;
          t[2] <= mode_held ? (TW0_TAIL ^ TW1_TAIL) : (TW0_HEAD ^ TW1_HEAD);
          x      <= blk;
          subkey <= '0;
          rnd    <= '0;
          pass   <= 1'b0;
          state  <= S_INJ;
        end
        S_INJ: begin
          if (subkey == LAST_SUBKEY) begin
            if (!pass) begin
              // Feed-forward, then key the output UBI
              blk_t mid;
              word_t par;
              par = KEY_PARITY;
              for (int i = 0; i < 8; i++) begin
                mid[i] = x_inj[i] ^ blk[i];
                par    = par ^ mid[i];
              end
              for (int i = 0; i < 8; i++) k[i] <= mid[i];
              k[8]   <= par;
              t[0]   <= TW0_OUT;
              t[1]   <= TW1_OUT;
              t[2]   <= TW0_OUT ^ TW1_OUT;
              x      <= '0;
              subkey <= '0;
              rnd    <= '0;
              pass   <= 1'b1;
            end else begin
              hash    <= x_inj;
              out_cnt <= '0;
              state   <= S_OUT;
            end
          end else begin
            x <= x_inj;
            // Rotate key schedule for next subkey
            for (int i = 0; i < 8; i++) k[i] <= k[i+1];
            k[8]   <= k[0];
            t[0]   <= t[1];
            t[1]   <= t[2];
            t[2]   <= t[0];
            subkey <= subkey + 5'd1;
            state  <= S_RND;
          end
        end
        S_RND: begin
          x   <= x_rnd;
          rnd <= rnd + 3'd1;
          if (rnd[1:0] == 2'd3) state <= S_INJ;
        end
        S_OUT: begin
          if (m_tready) begin
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == 3'd7) state <= S_COLLECT;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // Result word
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (out_cnt == 3'd7);
  always_comb begin
    m_tdata                 = '0;
    m_tdata[TAG_BITS-1:0]   = tag_held;
    m_tdata[TAG_BITS +: 64] = bswap64(hash[out_cnt]);
  end

endmodule

/* src/skn_checker.sv */
// Port-level checks for the Skein-512-512 hash core, bound to the top level.
// Depends on skein512_hash_core_top.
module skn_checker #(
  parameter int TAG_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic                    m_tlast,
  input logic [((TAG_BITS+64+7)/8)*8-1:0] m_tdata
);

  // No input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input ready during output");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed under stall");

  // Last word ends the burst
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("output continued after last word");

  // Reset leaves output idle
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid after reset");

endmodule

bind skein512_hash_core_top skn_checker #(.TAG_BITS(TAG_BITS)) u_skn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tdata  (m_tdata)
);

/* bench/testbench.sv */
// Self-checking bench for the Skein-512-512 hash core: a local Threefish predictor
// checks every hash word. Depends on skn_pkg and skein512_hash_core_top.
`timescale 1ns / 1ps

typedef struct {
  logic [7:0]     tag;
  skn_pkg::word_t hash;
  bit             last;
} hash_word_exp_t;

class hash_scoreboard;
  skn_pkg::word_t chain_key[8];
  skn_pkg::word_t word_store[8];
  int unsigned    word_count;
  bit             mode_held;
  logic [7:0]     tag_held;
  hash_word_exp_t pending_words[$];
  int unsigned    fail_count;

  function new();
    foreach (chain_key[i]) chain_key[i] = '0;
    foreach (word_store[i]) word_store[i] = '0;
    word_count = 0;
    mode_held  = 0;
    tag_held   = '0;
    fail_count = 0;
  endfunction

  function void set_key(int unsigned idx, skn_pkg::word_t val);
    if (idx < 8) chain_key[idx] = val;
  endfunction

  static function skn_pkg::word_t flip_bytes(skn_pkg::word_t v);
    skn_pkg::word_t r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
    return r;
  endfunction

  static function skn_pkg::word_t rotl(skn_pkg::word_t v, int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Threefish-512 encryption, 72 rounds and 19 subkey injections
  static function void encrypt(input skn_pkg::word_t key[8], input skn_pkg::word_t tw0,
                               input skn_pkg::word_t tw1,
                               input skn_pkg::word_t plain[8],
                               output skn_pkg::word_t cipher[8]);
    int rot[8][4] = '{'{46, 36, 19, 37}, '{33, 27, 14, 42}, '{17, 49, 36, 39},
                      '{44, 9, 54, 56}, '{39, 30, 34, 24}, '{13, 50, 10, 17},
                      '{25, 29, 39, 43}, '{8, 35, 56, 22}};
    skn_pkg::word_t k[9];
    skn_pkg::word_t t[3];
    skn_pkg::word_t x[8];
    skn_pkg::word_t y[8];
    skn_pkg::word_t sk;
    skn_pkg::word_t sum;
    int d;
    k[8] = 64'h1BD11BDAA9FC1A22;
    for (int i = 0; i < 8; i++) begin
      k[i] = key[i];
      k[8] ^= key[i];
      x[i] = plain[i];
    end
    t[0] = tw0;
    t[1] = tw1;
    t[2] = tw0 ^ tw1;
    for (int s = 0; s < 19; s++) begin
      for (int i = 0; i < 8; i++) begin
        sk = k[(s + i) % 9];
        if (i == 5) sk += t[s % 3];
        if (i == 6) sk += t[(s + 1) % 3];
        if (i == 7) sk += 64'(s);
        x[i] += sk;
      end
      if (s == 18) break;
      for (int r = 0; r < 4; r++) begin
        d = (s * 4 + r) % 8;
        for (int i = 0; i < 4; i++) begin
          sum = x[2*i] + x[2*i+1];
          y[2*i]   = sum;
          y[2*i+1] = sum ^ rotl(x[2*i+1], rot[d][i]);
        end
        x = '{y[2], y[1], y[4], y[7], y[6], y[5], y[0], y[3]};
      end
    end
    cipher = x;
  endfunction

  // Accepted input word; a completed message queues its eight hash words
  function void note_input(bit op, logic [7:0] tag, skn_pkg::word_t data);
    skn_pkg::word_t blk[8];
    skn_pkg::word_t mid[8];
    skn_pkg::word_t zero[8];
    skn_pkg::word_t digest[8];
    skn_pkg::word_t iv[8];
    int unsigned need;
    hash_word_exp_t e;
    if (word_count == 0) begin
      mode_held = op;
      tag_held  = tag;
    end
    word_store[word_count % 8] = data;
    word_count = (word_count + 1) % 16;
    need = mode_held ? 8 : 2;
    if (word_count < need) return;
    word_count = 0;
    for (int i = 0; i < 8; i++) begin
      blk[i]  = (i < need) ? flip_bytes(word_store[i]) : '0;
      zero[i] = '0;
      iv[i]   = skn_pkg::SKEIN_IV[i];
    end
    if (mode_held)
      encrypt(iv, 64'd64, 64'hF000000000000000, blk, mid);
    else
      encrypt(chain_key, 64'd80, 64'hB000000000000000, blk, mid);
    for (int i = 0; i < 8; i++) mid[i] ^= blk[i];
    encrypt(mid, 64'd8, 64'hFF00000000000000, zero, digest);
    for (int i = 0; i < 8; i++) begin
      e.tag  = tag_held;
      e.hash = flip_bytes(digest[i]);
      e.last = (i == 7);
      pending_words.push_back(e);
    end
  endfunction

  function void check_result(logic [7:0] tag, skn_pkg::word_t hash, logic last);
    hash_word_exp_t e;
    if (pending_words.size() == 0) begin
      $error("unexpected hash word: tag %0h hash %016h last %0b", tag, hash, last);
      fail_count++;
      return;
    end
    e = pending_words.pop_front();
    if (tag !== e.tag) begin
      $error("out_tag: expected %0h, actual %0h", e.tag, tag);
      fail_count++;
    end
    if (hash !== e.hash) begin
      $error("hash_word: expected %016h, actual %016h", e.hash, hash);
      fail_count++;
    end
    if (last !== e.last) begin
      $error("last_word: expected %0b, actual %0b", e.last, last);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import skn_pkg::*;

  localparam bit OP_HEAD = 1'b0;
  localparam bit OP_TAIL = 1'b1;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic        s_tuser = 0;
  logic [71:0] s_tdata = '0;   // tag [7:0], data_word [71:8]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;        // out_tag [7:0], hash_word [71:8]
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  hash_scoreboard sb = new();
  bit hold_long = 0;
  int unsigned words_sent = 0;

  skein512_hash_core_top dut (.*);

  always #1 clk = ~clk;

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[7:0], m_tdata[71:8], m_tlast);
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = hold_long ? 400 : $urandom_range(0, 5);
      hold_long = 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(bit op, logic [7:0] tag, word_t data, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {data, tag};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, tag, data);
    words_sent++;
  endtask

  // One message; noise changes mode and tag on later words, which must be ignored
  task automatic send_message(bit op, logic [7:0] tag, bit noise);
    int n;
    n = (op == OP_TAIL) ? 8 : 2;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && noise)
        send_word(1'($urandom_range(0, 1)), 8'($urandom), pick_word(), 0);
      else send_word(op, tag, pick_word(), 0);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Write all chain key words, plus one out-of-range index
  task automatic write_keys(input word_t keys[8]);
    for (int i = 0; i < 9; i++) begin
      cfg_valid <= 1;
      cfg_index <= (i < 8) ? 4'(i) : 4'($urandom_range(8, 15));
      cfg_data  <= (i < 8) ? keys[i] : {$urandom, $urandom};
      do @(posedge clk); while (!cfg_ready);
      sb.set_key(cfg_index, cfg_data);
    end
    cfg_valid <= 0;
  endtask

  initial begin
    word_t keys[8];
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, both modes, mid-message mode and tag changes
    send_word(OP_HEAD, 8'h00, '0, 0);
    send_word(OP_HEAD, 8'h00, '0, 0);
    send_word(OP_HEAD, 8'hFF, '1, 0);
    send_word(OP_TAIL, 8'h00, '1, 0);
    for (int i = 0; i < 8; i++) send_word(OP_TAIL, 8'hFF, '1, 1);
    send_word(OP_TAIL, 8'hA5, 64'h0123456789ABCDEF, 0);
    for (int i = 1; i < 8; i++) send_word(i[0] ? OP_HEAD : OP_TAIL, 8'(i), '0, 0);
    wait_drained();

    // Random phases with different chaining keys
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 8; i++)
        case (phase)
          0:       keys[i] = '1;
          1:       keys[i] = i[0] ? 64'hAAAAAAAAAAAAAAAA : 64'h5555555555555555;
          default: keys[i] = {$urandom, $urandom};
        endcase
      write_keys(keys);
      if (phase == 1) hold_long = 1;
      while (words_sent < 25 + 57 * (phase + 1)) begin
        send_message(1'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 4) == 0);
        if (phase == 2 && $urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
    end
    keys = '{default: '0};
    write_keys(keys);
    send_message(OP_HEAD, 8'h3C, 0);
    wait_drained();

    if (sb.fail_count == 0) $display("skein512_hash_core_top regression: pass");
    else $display("skein512_hash_core_top regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("skein512_hash_core_top regression: fail");
    $finish;
  end
endmodule
